@@ rtl/brf_pkg.sv @@
// Package for the byte ring FIFO: field widths, operation and status codes,
// and the per-beat result record passed from control to the result stage.
// No dependencies.
package brf_pkg;

  localparam int OP_W   = 2;
  localparam int DATA_W = 8;
  localparam int LEN_W  = 9;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;
  localparam logic [OP_W-1:0] OP_STATUS = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             use_rd;
    logic [ST_W-1:0]  status;
    logic [LEN_W-1:0] fill_count;
    logic             is_empty;
    logic             is_full;
  } brf_res_t;

endpackage

@@ rtl/byte_ring_fifo_top.sv @@
// Byte ring FIFO: one beat per cycle in (put, get, peek or status query), one
// result beat out per input beat, in order. Each beat is handled in the cycle
// it is accepted; its result passes the result stage, which meets the store's
// registered read data, and then the output register, and the block keeps
// taking one beat per cycle while the sink keeps up. A write to cfg_wr_data
// sets the length in use (zero acts as one, values above DEPTH saturate) and
// empties the FIFO. Entries are read only after they were written, so the
// store needs no clearing after reset.
module byte_ring_fifo_top #(
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [brf_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [brf_pkg::OP_W-1:0]   opcode,
  input  logic [brf_pkg::DATA_W-1:0] data_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [brf_pkg::DATA_W-1:0] read_byte,
  output logic [brf_pkg::ST_W-1:0]   status,
  output logic [brf_pkg::LEN_W-1:0]  fill_count,
  output logic                       is_empty,
  output logic                       is_full
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic                       accept;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic                       rd_en;
  logic [ADDR_W-1:0]          rd_addr;
  logic [brf_pkg::DATA_W-1:0] rd_data;
  brf_pkg::brf_res_t          res;

  assign accept = in_valid && in_ready;

  brf_ctrl #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .opcode      (opcode),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .res         (res)
  );

  brf_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (data_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  brf_out u_out (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .res_in     (res),
    .rd_data    (rd_data),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_byte  (read_byte),
    .status     (status),
    .fill_count (fill_count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

endmodule

@@ rtl/brf_store.sv @@
// Byte store of the ring FIFO: one write port and one read port, read data
// registered. Depends on brf_pkg for the data width.
module brf_store #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [brf_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [brf_pkg::DATA_W-1:0] rd_data
);

  logic [brf_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read data holds until the next read, so a stalled result keeps it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/brf_ctrl.sv @@
// Pointer and fill-count control of the ring FIFO: decodes each accepted beat,
// drives the store ports and builds the result record. Depends on brf_pkg.
module brf_ctrl #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [brf_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                       accept,
  input  logic [brf_pkg::OP_W-1:0]   opcode,
  output logic                       wr_en,
  output logic [ADDR_W-1:0]          wr_addr,
  output logic                       rd_en,
  output logic [ADDR_W-1:0]          rd_addr,
  output brf_pkg::brf_res_t          res
);

  localparam int LEN_W   = brf_pkg::LEN_W;
  localparam int CMP_W   = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 1;
  localparam int RST_LEN = (DEPTH < 256) ? DEPTH : 256;

  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  length_next;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] tail;
  logic [ADDR_W-1:0] head_next;
  logic [ADDR_W-1:0] tail_next;
  logic [LEN_W-1:0]  count;
  logic [LEN_W-1:0]  count_next;
  logic              is_full_now;
  logic              is_empty_now;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p,
                                                 input logic [LEN_W-1:0] len);
    logic [CMP_W-1:0] n;
    n = CMP_W'(p) + CMP_W'(1);
    return (n >= CMP_W'(len)) ? '0 : n[ADDR_W-1:0];
  endfunction

  // A zero length acts as one; a length beyond the store saturates.
  always_comb begin
    if (cfg_wr_data == '0) begin
      length_next = LEN_W'(1);
    end else if (32'(cfg_wr_data) > 32'(DEPTH)) begin
      length_next = LEN_W'(DEPTH);
    end else begin
      length_next = cfg_wr_data;
    end
  end

  assign is_full_now  = (count == length);
  assign is_empty_now = (count == '0);

  always_comb begin
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = tail;
    rd_addr    = head;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    res.use_rd = 1'b0;
    res.status = brf_pkg::ST_OK;
    case (opcode)
      brf_pkg::OP_PUT: begin
        if (is_full_now) begin
          res.status = brf_pkg::ST_FULL;
        end else begin
          wr_en      = accept;
          tail_next  = wrap_inc(tail, length);
          count_next = count + LEN_W'(1);
        end
      end
      brf_pkg::OP_GET, brf_pkg::OP_PEEK: begin
        if (is_empty_now) begin
          res.status = brf_pkg::ST_EMPTY;
        end else begin
          rd_en      = accept;
          res.use_rd = 1'b1;
          if (opcode == brf_pkg::OP_GET) begin
            head_next  = wrap_inc(head, length);
            count_next = count - LEN_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    res.fill_count = count_next;
    res.is_empty   = (count_next == '0);
    res.is_full    = (count_next == length);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= LEN_W'(RST_LEN);
      head   <= '0;
      tail   <= '0;
      count  <= '0;
    end else if (cfg_wr_en) begin
      length <= length_next;
      head   <= '0;
      tail   <= '0;
      count  <= '0;
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

endmodule

@@ rtl/brf_out.sv @@
// Result stage and output register of the ring FIFO. The result stage holds
// each beat beside the store's registered read data; the output register
// decouples the sink. Depends on brf_pkg.
module brf_out (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  brf_pkg::brf_res_t          res_in,
  input  logic [brf_pkg::DATA_W-1:0] rd_data,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [brf_pkg::DATA_W-1:0] read_byte,
  output logic [brf_pkg::ST_W-1:0]   status,
  output logic [brf_pkg::LEN_W-1:0]  fill_count,
  output logic                       is_empty,
  output logic                       is_full
);

  logic              s2_valid;
  brf_pkg::brf_res_t s2;
  logic              advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s2_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (advance) begin
        s2_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s2_valid;
      end
    end
  end

  // The store updates its read data at the same edge that a new beat is
  // accepted, so the beat leaving the result stage still samples its own byte.
  always_ff @(posedge clk) begin
    if (accept) begin
      s2 <= res_in;
    end
    if (advance && s2_valid) begin
      read_byte  <= s2.use_rd ? rd_data : '0;
      status     <= s2.status;
      fill_count <= s2.fill_count;
      is_empty   <= s2.is_empty;
      is_full    <= s2.is_full;
    end
  end

endmodule

@@ rtl/brf_checker.sv @@
// Port-level checks for the byte ring FIFO and the bind that attaches them
// to byte_ring_fifo_top. Depends on brf_pkg for status codes.
module brf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [brf_pkg::DATA_W-1:0] read_byte,
  input logic [brf_pkg::ST_W-1:0]   status,
  input logic [brf_pkg::LEN_W-1:0]  fill_count,
  input logic                       is_empty,
  input logic                       is_full
);

  // A result beat that waits keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_byte) && $stable(status)
      && $stable(fill_count))
    else $error("result beat changed while stalled");

  // An empty error reads nothing and reports an empty buffer.
  a_empty_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == brf_pkg::ST_EMPTY |-> read_byte == '0 && is_empty
      && fill_count == '0)
    else $error("empty error with data or nonzero fill");

  // A full error reports a full buffer.
  a_full_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == brf_pkg::ST_FULL |-> is_full && !is_empty)
    else $error("full error on a buffer that is not full");

  // The empty flag agrees with the fill count.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_empty == (fill_count == '0))
    else $error("empty flag disagrees with fill count");

endmodule

bind byte_ring_fifo_top brf_checker u_brf_checker (.*);

@@ test/tb_top.sv @@
// Testbench for byte_ring_fifo_top: directed and random put/get/peek/status
// beats checked against a ring buffer predictor held in this file.
// Depends on rtl/brf_pkg.sv and rtl/byte_ring_fifo_top.sv.
module tb_top;

  localparam int STORE_DEPTH = 256;
  localparam int RING_ADDR_W = $clog2(STORE_DEPTH);
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [brf_pkg::OP_W-1:0]   op_t;
  typedef logic [brf_pkg::DATA_W-1:0] byte_t;
  typedef logic [brf_pkg::LEN_W-1:0]  fill_t;
  typedef logic [RING_ADDR_W-1:0]     ring_idx_t;

  typedef struct packed {
    logic [brf_pkg::OP_W-1:0]   op;
    logic [brf_pkg::DATA_W-1:0] data;
  } access_t;

  typedef struct packed {
    logic [brf_pkg::DATA_W-1:0] read_byte;
    logic [brf_pkg::ST_W-1:0]   status;
    logic [brf_pkg::LEN_W-1:0]  fill_count;
    logic                       is_empty;
    logic                       is_full;
  } fifo_resp_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_wr_en = 1'b0;
  logic [brf_pkg::LEN_W-1:0]   cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [brf_pkg::OP_W-1:0]    opcode = brf_pkg::OP_STATUS;
  logic [brf_pkg::DATA_W-1:0]  data_in = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [brf_pkg::DATA_W-1:0]  read_byte;
  logic [brf_pkg::ST_W-1:0]    status;
  logic [brf_pkg::LEN_W-1:0]   fill_count;
  logic                        is_empty;
  logic                        is_full;

  // Predictor state: the ring contents, pointers and length in use.
  logic [brf_pkg::DATA_W-1:0]  ring_store [STORE_DEPTH];
  int                          ring_head = 0;
  int                          ring_tail = 0;
  int                          ring_len = STORE_DEPTH;
  bit                          ring_full = 1'b0;

  access_t            access_q [$];
  fifo_resp_t         fifo_resp_q [$];
  int                 accesses_in_flight = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 mismatches = 0;
  int                 resp_beats = 0;
  int                 cycle_count = 0;

  byte_ring_fifo_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .data_in     (data_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_byte   (read_byte),
    .status      (status),
    .fill_count  (fill_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int held_bytes();
    if (ring_full) return ring_len;
    if (ring_tail >= ring_head) return ring_tail - ring_head;
    return ring_len - ring_head + ring_tail;
  endfunction

  function automatic fifo_resp_t ring_access(access_t a);
    fifo_resp_t r;
    r = '0;
    case (a.op)
      brf_pkg::OP_PUT: begin
        if (held_bytes() >= ring_len) begin
          r.status = brf_pkg::ST_FULL;
        end else begin
          ring_store[ring_idx_t'(ring_tail)] = a.data;
          ring_tail = (ring_tail + 1 >= ring_len) ? 0 : ring_tail + 1;
          ring_full = (ring_tail == ring_head);
        end
      end
      brf_pkg::OP_GET, brf_pkg::OP_PEEK: begin
        if (held_bytes() == 0) begin
          r.status = brf_pkg::ST_EMPTY;
        end else begin
          r.read_byte = ring_store[ring_idx_t'(ring_head)];
          if (a.op == brf_pkg::OP_GET) begin
            ring_head = (ring_head + 1 >= ring_len) ? 0 : ring_head + 1;
            ring_full = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.fill_count = fill_t'(held_bytes());
    r.is_empty   = !ring_full && ring_head == ring_tail;
    r.is_full    = ring_full && ring_head == ring_tail;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("result beat %0d: %s is %0d, expected %0d", resp_beats, what, got, want);
    mismatches++;
  endtask

  task automatic queue_access(input logic [brf_pkg::OP_W-1:0] op,
                              input logic [brf_pkg::DATA_W-1:0] data);
    access_t a;
    a.op   = op;
    a.data = data;
    access_q.push_back(a);
    accesses_in_flight++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (accesses_in_flight != 0 || fifo_resp_q.size() != 0) @(negedge clk);
  endtask

  // The write also empties the FIFO, so the predictor pointers start over.
  task automatic write_length(input logic [brf_pkg::LEN_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ring_len  = (value == 0) ? 1 : (value > STORE_DEPTH) ? STORE_DEPTH : int'(value);
    ring_head = 0;
    ring_tail = 0;
    ring_full = 1'b0;
  endtask

  // Runs of puts and runs of pops push the ring through full and empty and
  // around the wrap point; short mixed runs and status beats fill the gaps.
  task automatic queue_random(input int count);
    int added;
    int burst;
    int pick;
    added = 0;
    while (added < count) begin
      pick  = $urandom_range(9);
      burst = (pick < 6) ? $urandom_range(1, ring_len + 2) : $urandom_range(1, 8);
      if (burst > count - added) burst = count - added;
      for (int k = 0; k < burst; k++) begin
        if (pick < 3)
          queue_access(brf_pkg::OP_PUT, byte_t'($urandom));
        else if (pick < 6)
          queue_access(($urandom_range(4) == 0) ? brf_pkg::OP_PEEK : brf_pkg::OP_GET,
                       byte_t'($urandom));
        else if (pick < 9)
          queue_access(op_t'($urandom_range(3)), byte_t'($urandom));
        else
          queue_access(brf_pkg::OP_STATUS, byte_t'($urandom));
      end
      added += burst;
    end
  endtask

  task automatic run_phase(input logic [brf_pkg::LEN_W-1:0] length, input int send_pct,
                           input int recv_pct, input int count, input bit fill_first);
    wait_drained();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    write_length(length);
    if (fill_first) begin
      for (int k = 0; k <= ring_len; k++) queue_access(brf_pkg::OP_PUT, byte_t'($urandom));
    end
    queue_random(count / 2);
    // Hold the sender back until every response is in before going on.
    wait_drained();
    queue_random(count - count / 2);
  endtask

  always @(posedge clk) begin : drive_access
    access_t cur;
    access_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cur.op   = opcode;
        cur.data = data_in;
        fifo_resp_q.push_back(ring_access(cur));
        accesses_in_flight--;
      end
      if (!in_valid || in_ready) begin
        if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = access_q.pop_front();
          in_valid <= 1'b1;
          opcode   <= nxt.op;
          data_in  <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_resp
    fifo_resp_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (fifo_resp_q.size() == 0) begin
          flag_mismatch("beat with nothing outstanding, fill_count", int'(fill_count), 0);
        end else begin
          want = fifo_resp_q.pop_front();
          if (read_byte !== want.read_byte)
            flag_mismatch("read_byte", int'(read_byte), int'(want.read_byte));
          if (status !== want.status)
            flag_mismatch("status", int'(status), int'(want.status));
          if (fill_count !== want.fill_count)
            flag_mismatch("fill_count", int'(fill_count), int'(want.fill_count));
          if (is_empty !== want.is_empty)
            flag_mismatch("is_empty", int'(is_empty), int'(want.is_empty));
          if (is_full !== want.is_full)
            flag_mismatch("is_full", int'(is_full), int'(want.is_full));
        end
        resp_beats++;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("byte_ring_fifo_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset length: pops and peeks on an empty ring, then a few bytes left in.
    queue_access(brf_pkg::OP_STATUS, 8'h00);
    queue_access(brf_pkg::OP_GET, 8'hFF);
    queue_access(brf_pkg::OP_PEEK, 8'h5A);
    queue_access(brf_pkg::OP_PUT, 8'h00);
    queue_access(brf_pkg::OP_PUT, 8'hFF);
    queue_access(brf_pkg::OP_PEEK, 8'h00);
    queue_access(brf_pkg::OP_GET, 8'h00);
    queue_access(brf_pkg::OP_STATUS, 8'hFF);
    queue_access(brf_pkg::OP_PUT, 8'h80);
    wait_drained();

    // Length of two written while bytes are held: full error and wrap.
    write_length(9'd2);
    queue_access(brf_pkg::OP_PUT, 8'h01);
    queue_access(brf_pkg::OP_PUT, 8'h7F);
    queue_access(brf_pkg::OP_PUT, 8'hAA);
    queue_access(brf_pkg::OP_STATUS, 8'h00);
    queue_access(brf_pkg::OP_PEEK, 8'h00);
    queue_access(brf_pkg::OP_GET, 8'h00);
    queue_access(brf_pkg::OP_GET, 8'h00);
    queue_access(brf_pkg::OP_GET, 8'h00);
    queue_access(brf_pkg::OP_PUT, 8'h33);
    queue_access(brf_pkg::OP_PUT, 8'h44);
    wait_drained();

    // A length of zero behaves as a single entry.
    write_length(9'd0);
    queue_access(brf_pkg::OP_PUT, 8'hC3);
    queue_access(brf_pkg::OP_PUT, 8'h3C);
    queue_access(brf_pkg::OP_PEEK, 8'h00);
    queue_access(brf_pkg::OP_GET, 8'h00);
    queue_access(brf_pkg::OP_GET, 8'h00);

    run_phase(9'd3, 0, 0, 120, 1'b0);
    run_phase(9'd17, 68, 0, 130, 1'b0);
    run_phase(9'd1, 0, 68, 100, 1'b0);
    run_phase(9'd511, 19, 19, 60, 1'b1);
    run_phase(9'd256, 0, 0, 100, 1'b0);
    run_phase(9'd2, 68, 0, 100, 1'b0);
    run_phase(fill_t'($urandom_range(4, 64)), 0, 68, 150, 1'b0);
    run_phase(9'd255, 19, 19, 60, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("byte_ring_fifo_top test passed");
    else
      $display("byte_ring_fifo_top test failed");
    $finish;
  end

endmodule
